// ===== rtl/core/dcsv_pkg.sv =====
// ----------------------------------------------------------------------------
// dcsv_pkg
// Shared types and constants for the delimited command to servo value block.
// ----------------------------------------------------------------------------
package dcsv_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEP   = 8'h7C;

    // Field parse phases
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // Field numbers
    localparam logic [1:0] FLD_THR  = 2'd0;
    localparam logic [1:0] FLD_ANG1 = 2'd1;
    localparam logic [1:0] FLD_ANG2 = 2'd2;
    localparam logic [1:0] FLD_PAST = 2'd3;

    localparam logic [9:0]  VALUE_MAX = 10'd1023;
    localparam logic [10:0] ACC_CAP   = 11'd1024;

    // Configuration register indexes
    localparam logic [1:0] CFG_THR_LO = 2'd0;
    localparam logic [1:0] CFG_THR_HI = 2'd1;
    localparam logic [1:0] CFG_ANG_LO = 2'd2;
    localparam logic [1:0] CFG_ANG_HI = 2'd3;

    localparam logic [11:0] THR_LO_RST = 12'd1000;
    localparam logic [11:0] THR_HI_RST = 12'd2000;
    localparam logic [7:0]  ANG_LO_RST = 8'd0;
    localparam logic [7:0]  ANG_HI_RST = 8'd180;

    // value (10 bits) times |high - low| (12 bits)
    localparam int PROD_W = 22;

    typedef struct packed {
        logic       take;       // byte item accepted
        logic       snap;       // accepted byte ends the packet
        logic       mul_load;   // form product for field fld
        logic       div_step;   // quotient by reciprocal multiply
        logic       res_store;  // finish field fld
        logic       out_load;   // move results to output registers
        logic [1:0] fld;
    } cmd_t;

endpackage

// ===== rtl/core/dcsv_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcsv_ctrl
// Sequencer: input/output handshakes and the per-field multiply/divide steps.
// ----------------------------------------------------------------------------
module dcsv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             packet_last,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output dcsv_pkg::cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_ADD  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t                      state_reg, state_next;
    logic [1:0]                  fld_reg, fld_next;
    logic                        ovld_reg, ovld_next;
    logic                        in_fire;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_valid = ovld_reg;

    always_comb
    begin
        state_next   = state_reg;
        fld_next     = fld_reg;
        ovld_next    = ovld_reg;
        cmd          = '0;
        cmd.fld      = fld_reg;
        cmd.take     = in_fire;
        cmd.snap     = in_fire && packet_last;

        if (ovld_reg && !out_stall)
        begin
            ovld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && packet_last)
                begin
                    fld_next   = dcsv_pkg::FLD_THR;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.res_store = 1'b1;
                if (fld_reg == dcsv_pkg::FLD_ANG2)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    fld_next   = fld_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                // wait for the previous result to leave
                if (!ovld_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    ovld_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fld_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fld_reg   <= fld_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule

// ===== rtl/core/dcsv_datapath.sv =====
// ----------------------------------------------------------------------------
// dcsv_datapath
// Byte parser, configuration registers, and the multiply / reciprocal-divide
// scaler with result and output registers.
// ----------------------------------------------------------------------------
module dcsv_datapath #(
    parameter int FULL_SCALE = 1023
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dcsv_pkg::cmd_t   cmd,
    input  logic [7:0]       packet_byte,
    input  logic             packet_last,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [11:0]      cfg_data,
    output logic [11:0]      throttle_pulse,
    output logic [7:0]       first_angle,
    output logic [7:0]       second_angle
);

    localparam int PW = dcsv_pkg::PROD_W;
    // floor(n / FULL_SCALE) = (n * RECIP) >> SH, exact for every PW-bit n
    localparam int SH = PW + $clog2(FULL_SCALE);
    localparam int RW = PW + 1;
    localparam int QW = PW + RW;
    localparam longint RECIP_L =
        ((longint'(1) << SH) + longint'(FULL_SCALE - 1)) / longint'(FULL_SCALE);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

    typedef struct packed {
        logic [1:0]       fld_num;
        logic [1:0]       phase;
        logic             neg;
        logic [10:0]      acc;
        logic             ended;
        logic [2:0][9:0]  vals;
    } parse_t;

    function automatic parse_t close_field(input parse_t p);
        parse_t     q;
        logic [9:0] v;
        q = p;
        if (p.fld_num != dcsv_pkg::FLD_PAST)
        begin
            if (p.neg)
                v = '0;
            else if (p.acc > 11'(dcsv_pkg::VALUE_MAX))
                v = dcsv_pkg::VALUE_MAX;
            else
                v = p.acc[9:0];
            q.vals[p.fld_num] = v;
            q.fld_num         = p.fld_num + 1'b1;
        end
        q.phase = dcsv_pkg::PH_SKIP;
        q.neg   = 1'b0;
        q.acc   = '0;
        return q;
    endfunction

    function automatic parse_t take_char(input parse_t p, input logic [7:0] c);
        parse_t      q;
        logic        dig;
        logic [13:0] a;
        q   = p;
        dig = (c >= dcsv_pkg::CH_ZERO) && (c <= dcsv_pkg::CH_NINE);
        a   = ({3'b0, p.acc} * 14'd10) + {10'b0, c[3:0]};
        if (c == dcsv_pkg::CH_SEP)
        begin
            q = close_field(p);
        end
        else if (p.fld_num != dcsv_pkg::FLD_PAST)
        begin
            case (p.phase)
                dcsv_pkg::PH_SKIP:
                begin
                    if (c == dcsv_pkg::CH_SPACE)
                    begin
                        q.phase = dcsv_pkg::PH_SKIP;
                    end
                    else if (c == dcsv_pkg::CH_PLUS || c == dcsv_pkg::CH_MINUS)
                    begin
                        q.neg   = (c == dcsv_pkg::CH_MINUS);
                        q.phase = dcsv_pkg::PH_SIGN;
                    end
                    else if (dig)
                    begin
                        q.acc   = {7'b0, c[3:0]};
                        q.phase = dcsv_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        q.phase = dcsv_pkg::PH_DONE;
                    end
                end
                dcsv_pkg::PH_SIGN, dcsv_pkg::PH_DIGITS:
                begin
                    if (dig)
                    begin
                        q.acc   = (a > 14'(dcsv_pkg::ACC_CAP)) ? dcsv_pkg::ACC_CAP : a[10:0];
                        q.phase = dcsv_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        q.phase = dcsv_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    q.phase = p.phase;
                end
            endcase
        end
        return q;
    endfunction

    // ---------------- parser ----------------
    parse_t           parse_reg, parse_next;
    logic [2:0][9:0]  snap_reg;

    always_comb
    begin
        parse_next = parse_reg;
        if (!parse_reg.ended)
        begin
            if (packet_byte == dcsv_pkg::CH_NUL)
            begin
                parse_next       = close_field(parse_reg);
                parse_next.ended = 1'b1;
            end
            else
            begin
                parse_next = take_char(parse_reg, packet_byte);
            end
        end
        if (packet_last && !parse_next.ended)
        begin
            parse_next = close_field(parse_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg <= '0;
        end
        else if (cmd.snap)
        begin
            parse_reg <= '0;
        end
        else if (cmd.take)
        begin
            parse_reg <= parse_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap)
        begin
            snap_reg <= parse_next.vals;
        end
    end

    // ---------------- configuration ----------------
    logic [11:0] thr_lo_reg, thr_hi_reg;
    logic [7:0]  ang_lo_reg, ang_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_lo_reg <= dcsv_pkg::THR_LO_RST;
            thr_hi_reg <= dcsv_pkg::THR_HI_RST;
            ang_lo_reg <= dcsv_pkg::ANG_LO_RST;
            ang_hi_reg <= dcsv_pkg::ANG_HI_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dcsv_pkg::CFG_THR_LO: thr_lo_reg <= cfg_data;
                dcsv_pkg::CFG_THR_HI: thr_hi_reg <= cfg_data;
                dcsv_pkg::CFG_ANG_LO: ang_lo_reg <= cfg_data[7:0];
                dcsv_pkg::CFG_ANG_HI: ang_hi_reg <= cfg_data[7:0];
                default:              thr_lo_reg <= thr_lo_reg;
            endcase
        end
    end

    // ---------------- scaler ----------------
    logic [11:0]    lo_sel, hi_sel, mag;
    logic [12:0]    diff;
    logic [9:0]     val_sel;
    logic [PW-1:0]  prod;
    logic [QW-1:0]  qprod, qshift;
    logic [PW-1:0]  sq, res;

    logic [PW-1:0]  quo_reg;
    logic           sneg_reg;
    logic [11:0]    slo_reg;
    logic [11:0]    thr_res_reg;
    logic [7:0]     a1_res_reg, a2_res_reg;
    logic [11:0]    thr_out_reg;
    logic [7:0]     a1_out_reg, a2_out_reg;

    always_comb
    begin
        if (cmd.fld == dcsv_pkg::FLD_THR)
        begin
            lo_sel = thr_lo_reg;
            hi_sel = thr_hi_reg;
        end
        else
        begin
            lo_sel = {4'b0, ang_lo_reg};
            hi_sel = {4'b0, ang_hi_reg};
        end
        diff = {1'b0, hi_sel} - {1'b0, lo_sel};
        mag  = diff[12] ? 12'(13'd0 - diff) : diff[11:0];
        case (cmd.fld)
            dcsv_pkg::FLD_THR:  val_sel = snap_reg[0];
            dcsv_pkg::FLD_ANG1: val_sel = snap_reg[1];
            default:            val_sel = snap_reg[2];
        endcase
        prod = PW'(val_sel) * PW'(mag);

        // divide the held product by FULL_SCALE
        qprod  = QW'(quo_reg) * QW'(RECIP);
        qshift = qprod >> SH;

        sq  = sneg_reg ? (PW'(0) - quo_reg) : quo_reg;
        res = PW'(slo_reg) + sq;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            quo_reg  <= prod;
            sneg_reg <= diff[12];
            slo_reg  <= lo_sel;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= qshift[PW-1:0];
        end

        if (cmd.res_store)
        begin
            case (cmd.fld)
                dcsv_pkg::FLD_THR:  thr_res_reg <= res[11:0];
                dcsv_pkg::FLD_ANG1: a1_res_reg  <= res[7:0];
                default:            a2_res_reg  <= res[7:0];
            endcase
        end

        if (cmd.out_load)
        begin
            thr_out_reg <= thr_res_reg;
            a1_out_reg  <= a1_res_reg;
            a2_out_reg  <= a2_res_reg;
        end
    end

    assign throttle_pulse = thr_out_reg;
    assign first_angle    = a1_out_reg;
    assign second_angle   = a2_out_reg;

endmodule

// ===== rtl/core/delimited_command_to_servo_values.sv =====
// ----------------------------------------------------------------------------
// delimited_command_to_servo_values
// Parses "a|b|c" command text one byte item per cycle and, on the byte marked
// last, gives one item: a throttle pulse width and two servo angles, each
// value (saturated to 0..1023) scaled as low + value*(high-low)/FULL_SCALE,
// truncated toward zero. Bytes are taken at one per cycle. After the byte
// marked last is accepted, in_stall is high while the three fields go one
// after another through a multiply state, a divide state (a multiply by
// the reciprocal of FULL_SCALE) and an add state, followed by a state that
// loads the output register; that state waits only while the previous
// result is still held on the output. The result then waits in an
// output register, and the next packet's bytes are accepted meanwhile.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module delimited_command_to_servo_values #(
    parameter int FULL_SCALE = 1023
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   packet_byte,
    input  logic         packet_last,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [11:0]  throttle_pulse,
    output logic [7:0]   first_angle,
    output logic [7:0]   second_angle,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [11:0]  cfg_data
);

    dcsv_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    dcsv_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .packet_last (packet_last),
        .in_stall    (in_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd         (cmd)
    );

    dcsv_datapath #(
        .FULL_SCALE (FULL_SCALE)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .packet_byte    (packet_byte),
        .packet_last    (packet_last),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .throttle_pulse (throttle_pulse),
        .first_angle    (first_angle),
        .second_angle   (second_angle)
    );

    // a packet end always starts the scaler
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && packet_last |=> in_stall)
        else $error("packet end did not start scaling");

    // ordinary bytes never stall the next cycle
    a_byte_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !packet_last |=> !in_stall)
        else $error("stall after an ordinary byte");

    // a new result only comes out of the scaling sequence
    a_result_from_scaler: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without scaling");

endmodule
